// ===== hdl/gpp_pkg.sv =====
// Shared types and constants for the GIF tag path parser.
// No dependencies; used by every module of the block and by its checker.
package gpp_pkg;

  // Result kinds
  localparam logic [2:0] QK_TAG     = 3'd0;
  localparam logic [2:0] QK_PACKED  = 3'd1;
  localparam logic [2:0] QK_REGLIST = 3'd2;
  localparam logic [2:0] QK_IMAGE   = 3'd3;
  localparam logic [2:0] QK_NONE    = 3'd4;

  // Input kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Tag modes
  localparam logic [1:0] MODE_PACKED  = 2'd0;
  localparam logic [1:0] MODE_REGLIST = 2'd1;

  // A+D descriptor and the register addresses it acts on
  localparam logic [3:0] DESC_AD     = 4'he;
  localparam logic [7:0] ADDR_SIGNAL = 8'h60;
  localparam logic [7:0] ADDR_FINISH = 8'h61;
  localparam logic [7:0] ADDR_LABEL  = 8'h62;

  typedef struct packed {
    logic        kind;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
  } gpp_in_t;

  typedef struct packed {
    logic [2:0]  qword_kind;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic        second_valid;
    logic [63:0] out_lo;
    logic [63:0] out_hi;
    logic        end_of_packet;
    logic        signal_irq;
    logic        finish_flag;
    logic        stalled;
    logic [31:0] signal_id;
    logic [31:0] label_id;
  } gpp_out_t;

endpackage

// ===== hdl/gpp_core.sv =====
// Parser state and single-pass next-state and result logic.
// Depends on gpp_pkg for the item and result types and the codes.
module gpp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             step_i,
  input  gpp_pkg::gpp_in_t item_i,
  output gpp_pkg::gpp_out_t res_o
);

  logic        irq_mask_q;
  logic [14:0] loop_cnt_q, loop_cnt_d;
  logic [3:0]  reg_idx_q, reg_idx_d;
  logic [4:0]  reg_total_q, reg_total_d;
  logic [1:0]  mode_q, mode_d;
  logic        eop_bit_q, eop_bit_d;
  logic [63:0] reg_list_q, reg_list_d;
  logic        sig_stat_q, sig_stat_d;
  logic        fin_stat_q, fin_stat_d;
  logic        dbl_pend_q, dbl_pend_d;
  logic [31:0] sig_id_q, sig_id_d;
  logic [31:0] lbl_id_q, lbl_id_d;

  // Register steps: first and second register of this qword
  logic [3:0]  desc0, desc1, idx1, idx2;
  logic [4:0]  nxt0, nxt1;
  logic [14:0] loop1, loop2;
  logic [31:0] wr_val, wr_msk;

  assign desc0 = reg_list_q[{reg_idx_q, 2'b00} +: 4];
  assign nxt0  = {1'b0, reg_idx_q} + 5'd1;
  assign idx1  = (nxt0 >= reg_total_q) ? 4'd0 : nxt0[3:0];
  assign loop1 = (nxt0 >= reg_total_q) ? loop_cnt_q - 15'd1 : loop_cnt_q;
  assign desc1 = reg_list_q[{idx1, 2'b00} +: 4];
  assign nxt1  = {1'b0, idx1} + 5'd1;
  assign idx2  = (nxt1 >= reg_total_q) ? 4'd0 : nxt1[3:0];
  assign loop2 = (nxt1 >= reg_total_q) ? loop1 - 15'd1 : loop1;

  assign wr_val = item_i.data_lo[31:0];
  assign wr_msk = item_i.data_lo[63:32];

  // Work out the next state and the result of the item
  always_comb begin
    loop_cnt_d  = loop_cnt_q;
    reg_idx_d   = reg_idx_q;
    reg_total_d = reg_total_q;
    mode_d      = mode_q;
    eop_bit_d   = eop_bit_q;
    reg_list_d  = reg_list_q;
    sig_stat_d  = sig_stat_q;
    fin_stat_d  = fin_stat_q;
    dbl_pend_d  = dbl_pend_q;
    sig_id_d    = sig_id_q;
    lbl_id_d    = lbl_id_q;
    res_o            = '0;
    res_o.qword_kind = gpp_pkg::QK_NONE;

    if (item_i.kind == gpp_pkg::KIND_CLEAR) begin
      sig_stat_d = 1'b0;
      fin_stat_d = 1'b0;
      dbl_pend_d = 1'b0;
    end else if (dbl_pend_q) begin
      res_o.stalled = 1'b1;
    end else if (loop_cnt_q == 15'd0) begin
      // Tag: load loop count, flags and register list
      loop_cnt_d  = item_i.data_lo[14:0];
      eop_bit_d   = item_i.data_lo[15];
      mode_d      = item_i.data_lo[59:58];
      reg_total_d = (item_i.data_lo[63:60] == 4'd0) ? 5'd16 : {1'b0, item_i.data_lo[63:60]};
      reg_list_d  = item_i.data_hi;
      reg_idx_d   = 4'd0;
      res_o.qword_kind = gpp_pkg::QK_TAG;
      res_o.out_lo     = item_i.data_lo;
      res_o.out_hi     = item_i.data_hi;
    end else if (mode_q == gpp_pkg::MODE_PACKED) begin
      res_o.qword_kind = gpp_pkg::QK_PACKED;
      res_o.reg_first  = desc0;
      res_o.out_lo     = item_i.data_lo;
      res_o.out_hi     = item_i.data_hi;
      if (desc0 == gpp_pkg::DESC_AD) begin
        if (item_i.data_hi[7:0] == gpp_pkg::ADDR_SIGNAL) begin
          if (sig_stat_q) begin
            // Second SIGNAL: consume the qword and hold further data
            dbl_pend_d    = 1'b1;
            res_o.stalled = 1'b1;
            res_o.out_lo  = '0;
            res_o.out_hi  = '0;
          end else begin
            sig_id_d         = (sig_id_q & ~wr_msk) | (wr_val & wr_msk);
            res_o.signal_irq = ~irq_mask_q;
            sig_stat_d       = 1'b1;
          end
        end else if (item_i.data_hi[7:0] == gpp_pkg::ADDR_FINISH) begin
          fin_stat_d = 1'b1;
        end else if (item_i.data_hi[7:0] == gpp_pkg::ADDR_LABEL) begin
          lbl_id_d = (lbl_id_q & ~wr_msk) | (wr_val & wr_msk);
        end
      end
      reg_idx_d  = idx1;
      loop_cnt_d = loop1;
    end else if (mode_q == gpp_pkg::MODE_REGLIST) begin
      res_o.qword_kind = gpp_pkg::QK_REGLIST;
      res_o.reg_first  = desc0;
      res_o.out_lo     = item_i.data_lo;
      res_o.out_hi     = item_i.data_hi;
      // Skip the upper half when the list ends on the lower one
      if (loop1 != 15'd0) begin
        res_o.reg_second   = desc1;
        res_o.second_valid = 1'b1;
        reg_idx_d          = idx2;
        loop_cnt_d         = loop2;
      end else begin
        reg_idx_d  = idx1;
        loop_cnt_d = loop1;
      end
    end else begin
      res_o.qword_kind = gpp_pkg::QK_IMAGE;
      res_o.out_lo     = item_i.data_lo;
      res_o.out_hi     = item_i.data_hi;
      loop_cnt_d       = loop_cnt_q - 15'd1;
    end

    res_o.end_of_packet = (res_o.qword_kind != gpp_pkg::QK_NONE) && eop_bit_d &&
                          (loop_cnt_d == 15'd0);
    res_o.finish_flag   = fin_stat_d;
    res_o.signal_id     = sig_id_d;
    res_o.label_id      = lbl_id_d;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_mask_q <= 1'b1;
    end else if (cfg_we_i) begin
      irq_mask_q <= cfg_wdata_i;
    end
  end

  // Advance the parser state once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_cnt_q  <= '0;
      reg_idx_q   <= '0;
      reg_total_q <= '0;
      mode_q      <= '0;
      eop_bit_q   <= 1'b1;
      reg_list_q  <= '0;
      sig_stat_q  <= 1'b0;
      fin_stat_q  <= 1'b0;
      dbl_pend_q  <= 1'b0;
      sig_id_q    <= '0;
      lbl_id_q    <= '0;
    end else if (step_i) begin
      loop_cnt_q  <= loop_cnt_d;
      reg_idx_q   <= reg_idx_d;
      reg_total_q <= reg_total_d;
      mode_q      <= mode_d;
      eop_bit_q   <= eop_bit_d;
      reg_list_q  <= reg_list_d;
      sig_stat_q  <= sig_stat_d;
      fin_stat_q  <= fin_stat_d;
      dbl_pend_q  <= dbl_pend_d;
      sig_id_q    <= sig_id_d;
      lbl_id_q    <= lbl_id_d;
    end
  end

endmodule

// ===== hdl/giftag_path_parser.sv =====
// Top level of the GIF tag path parser: input register, parser core, result register.
// Depends on gpp_pkg and gpp_core.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o | in_item_i  (gpp_in_t)
//  out     | output    | out_valid_o/ out_stall_i| out_item_o (gpp_out_t)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (irq mask)
//
// One item per cycle sustained unless the output stalls; a result is offered from
// the cycle after the edge that moves its item out of the input register.
// The parser core updates its state as the item moves from the input register
// into the result register, so a stall on the output holds both stages.
// in_stall_o rises only when both stages are full and the output is stalled.
// Reset clears the handshake state and the parser state; the IRQ mask resets to 1.
module giftag_path_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gpp_pkg::gpp_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gpp_pkg::gpp_out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);

  logic              in_valid_q;
  gpp_pkg::gpp_in_t  in_item_q;
  logic              out_valid_q;
  gpp_pkg::gpp_out_t out_item_q;
  gpp_pkg::gpp_out_t res;
  logic              advance;
  logic              in_xfer;
  logic              step;

  // Move forward whenever the result register is free or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && advance;

  gpp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (in_item_q),
    .res_o       (res)
  );

  // Input register valid and result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hdl/gpp_checker.sv =====
// Port-level checker for the GIF tag path parser, bound to the top level.
// Depends on gpp_pkg and giftag_path_parser.
module gpp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input gpp_pkg::gpp_out_t out_item_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // An interrupt only comes from an accepted packed SIGNAL
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.signal_irq |->
      out_item_o.qword_kind == gpp_pkg::QK_PACKED && !out_item_o.stalled)
    else $error("interrupt on a qword that is not an accepted SIGNAL");

  // The upper half is only used by register-list qwords
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.second_valid |->
      out_item_o.qword_kind == gpp_pkg::QK_REGLIST)
    else $error("second register outside register-list mode");

  // No qword passed on means no data and no end of packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.qword_kind == gpp_pkg::QK_NONE |->
      out_item_o.out_lo == 64'd0 && out_item_o.out_hi == 64'd0 &&
      !out_item_o.end_of_packet)
    else $error("data or end of packet on an empty result");

endmodule

bind giftag_path_parser gpp_checker u_gpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== tb/sv/tb_giftag_path_parser.sv =====
// Self-checking testbench for the GIF tag path parser: directed packets, random traffic,
// output hold-off and a long back-to-back image burst, all checked against an in-bench model.
// Depends on gpp_pkg and the giftag_path_parser RTL.
module tb_giftag_path_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // Image modes and an A+D address that the parser must ignore
  localparam logic [1:0] MODE_IMAGE      = 2'd2;
  localparam logic [1:0] MODE_IMAGE_ALT  = 2'd3;
  localparam logic [7:0] ADDR_UNUSED     = 8'h63;

  localparam int IDLE_PCT        = 16;
  localparam int OUT_HOLD_CYCLES = 100;
  localparam int CYCLE_LIMIT     = 500_000;
  localparam int DRAIN_LIMIT     = 1_000;
  localparam int MAX_REPORTS     = 50;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  gpp_pkg::gpp_in_t  in_item_i;
  logic              out_valid_o;
  logic              out_stall_i;
  gpp_pkg::gpp_out_t out_item_o;
  logic              cfg_we_i;
  logic              cfg_wdata_i;

  giftag_path_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Parser state as predicted by the bench
  logic        p_irq_mask  = 1'b1;
  logic [14:0] p_loops     = '0;
  logic [3:0]  p_reg_idx   = '0;
  logic [4:0]  p_reg_total = '0;
  logic [1:0]  p_mode      = '0;
  logic        p_eop       = 1'b1;
  logic [63:0] p_reg_list  = '0;
  logic        p_sig_st    = 1'b0;
  logic        p_fin_st    = 1'b0;
  logic        p_dbl       = 1'b0;
  logic [31:0] p_sig_id    = '0;
  logic [31:0] p_lbl_id    = '0;

  gpp_pkg::gpp_out_t qword_result_q[$];
  int       mismatches      = 0;
  int       results_checked = 0;
  int       items_sent      = 0;
  int       in_idle_pct     = IDLE_PCT;
  int       out_idle_pct    = IDLE_PCT;
  int       hold_requests   = 0;
  int       hold_served     = 0;
  int       hold_left       = 0;

  // Clock and the single reset at the start
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] cur_reg();
    return p_reg_list[{p_reg_idx, 2'b00} +: 4];
  endfunction

  // Move to the next register; spend one loop when the list wraps
  function automatic void step_register();
    logic [4:0] nxt;
    nxt = {1'b0, p_reg_idx} + 5'd1;
    if (nxt >= p_reg_total) begin
      p_reg_idx = '0;
      p_loops   = p_loops - 15'd1;
    end else begin
      p_reg_idx = nxt[3:0];
    end
  endfunction

  function automatic logic [31:0] masked_id(logic [31:0] old, logic [63:0] d);
    return (old & ~d[63:32]) | (d[31:0] & d[63:32]);
  endfunction

  function automatic gpp_pkg::gpp_out_t parse_qword(gpp_pkg::gpp_in_t it);
    gpp_pkg::gpp_out_t r;
    r            = '0;
    r.qword_kind = gpp_pkg::QK_NONE;
    if (it.kind == gpp_pkg::KIND_CLEAR) begin
      p_sig_st = 1'b0;
      p_fin_st = 1'b0;
      p_dbl    = 1'b0;
    end else if (p_dbl) begin
      r.stalled = 1'b1;
    end else if (p_loops == '0) begin
      // Tag: load loop count, flags and the register list
      p_loops     = it.data_lo[14:0];
      p_eop       = it.data_lo[15];
      p_mode      = it.data_lo[59:58];
      p_reg_total = (it.data_lo[63:60] == 4'd0) ? 5'd16 : {1'b0, it.data_lo[63:60]};
      p_reg_list  = it.data_hi;
      p_reg_idx   = '0;
      r.qword_kind = gpp_pkg::QK_TAG;
      r.out_lo     = it.data_lo;
      r.out_hi     = it.data_hi;
    end else if (p_mode == gpp_pkg::MODE_PACKED) begin
      r.qword_kind = gpp_pkg::QK_PACKED;
      r.reg_first  = cur_reg();
      r.out_lo     = it.data_lo;
      r.out_hi     = it.data_hi;
      if (r.reg_first == gpp_pkg::DESC_AD) begin
        case (it.data_hi[7:0])
          gpp_pkg::ADDR_SIGNAL: begin
            if (p_sig_st) begin
              // second SIGNAL: consume the qword and hold further data
              p_dbl     = 1'b1;
              r.stalled = 1'b1;
              r.out_lo  = '0;
              r.out_hi  = '0;
            end else begin
              p_sig_id     = masked_id(p_sig_id, it.data_lo);
              r.signal_irq = ~p_irq_mask;
              p_sig_st     = 1'b1;
            end
          end
          gpp_pkg::ADDR_FINISH: p_fin_st = 1'b1;
          gpp_pkg::ADDR_LABEL:  p_lbl_id = masked_id(p_lbl_id, it.data_lo);
          default: ;
        endcase
      end
      step_register();
    end else if (p_mode == gpp_pkg::MODE_REGLIST) begin
      r.qword_kind = gpp_pkg::QK_REGLIST;
      r.out_lo     = it.data_lo;
      r.out_hi     = it.data_hi;
      r.reg_first  = cur_reg();
      step_register();
      // skip the upper half when the list ended on the lower one
      if (p_loops != '0) begin
        r.reg_second   = cur_reg();
        r.second_valid = 1'b1;
        step_register();
      end
    end else begin
      r.qword_kind = gpp_pkg::QK_IMAGE;
      r.out_lo     = it.data_lo;
      r.out_hi     = it.data_hi;
      p_loops      = p_loops - 15'd1;
    end
    r.end_of_packet = (r.qword_kind != gpp_pkg::QK_NONE) && p_eop && (p_loops == '0);
    r.finish_flag   = p_fin_st;
    r.signal_id     = p_sig_id;
    r.label_id      = p_lbl_id;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic gpp_pkg::gpp_in_t random_qword();
    gpp_pkg::gpp_in_t it;
    it.kind    = gpp_pkg::KIND_DATA;
    it.data_lo = {$urandom, $urandom};
    it.data_hi = {$urandom, $urandom};
    return it;
  endfunction

  function automatic gpp_pkg::gpp_in_t clear_item();
    gpp_pkg::gpp_in_t it;
    it      = random_qword();
    it.kind = gpp_pkg::KIND_CLEAR;
    return it;
  endfunction

  function automatic gpp_pkg::gpp_in_t tag_qword(logic [14:0] loops, logic eop,
                                                 logic [1:0] mode, logic [3:0] nreg,
                                                 logic [63:0] regs);
    gpp_pkg::gpp_in_t it;
    it.kind             = gpp_pkg::KIND_DATA;
    it.data_lo          = '0;
    it.data_lo[14:0]    = loops;
    it.data_lo[15]      = eop;
    it.data_lo[59:58]   = mode;
    it.data_lo[63:60]   = nreg;
    it.data_hi          = regs;
    return it;
  endfunction

  function automatic gpp_pkg::gpp_in_t ad_qword(logic [7:0] addr, logic [63:0] lo);
    gpp_pkg::gpp_in_t it;
    it              = random_qword();
    it.data_lo      = lo;
    it.data_hi[7:0] = addr;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer one item, hold it until the transfer, then predict
  // ---------------------------------------------------------------------------
  task automatic send_qword(gpp_pkg::gpp_in_t it);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    qword_result_q.push_back(parse_qword(it));
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic wait_parser_idle();
    in_valid_i <= 1'b0;
    while (qword_result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_irq_mask(logic mask);
    wait_parser_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    p_irq_mask  = mask;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : receiver
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = OUT_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left    = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                results_checked, name, got, want));
  endtask

  // Compare each transfer on the output with the oldest prediction
  always @(posedge clk_i) begin : result_checker
    gpp_pkg::gpp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (qword_result_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, kind %0d",
                                  out_item_o.qword_kind));
      end else begin
        want = qword_result_q.pop_front();
        compare_field("qword_kind",    64'(out_item_o.qword_kind),
                      64'(want.qword_kind));
        compare_field("reg_first",     64'(out_item_o.reg_first),
                      64'(want.reg_first));
        compare_field("reg_second",    64'(out_item_o.reg_second),
                      64'(want.reg_second));
        compare_field("second_valid",  64'(out_item_o.second_valid),
                      64'(want.second_valid));
        compare_field("out_lo",        out_item_o.out_lo,        want.out_lo);
        compare_field("out_hi",        out_item_o.out_hi,        want.out_hi);
        compare_field("end_of_packet", 64'(out_item_o.end_of_packet),
                      64'(want.end_of_packet));
        compare_field("signal_irq",    64'(out_item_o.signal_irq),
                      64'(want.signal_irq));
        compare_field("finish_flag",   64'(out_item_o.finish_flag),
                      64'(want.finish_flag));
        compare_field("stalled",       64'(out_item_o.stalled),
                      64'(want.stalled));
        compare_field("signal_id",     64'(out_item_o.signal_id),
                      64'(want.signal_id));
        compare_field("label_id",      64'(out_item_o.label_id),
                      64'(want.label_id));
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Packed A+D writes: SIGNAL, LABEL, FINISH, an ignored address, double SIGNAL,
  // a rejected qword while stalled, host clear, then a fresh SIGNAL ending the packet
  task automatic test_packed_ad_writes();
    send_qword(tag_qword(15'd6, 1'b1, gpp_pkg::MODE_PACKED, 4'd1,
                         {60'hfedcba987654321, gpp_pkg::DESC_AD}));
    send_qword(ad_qword(gpp_pkg::ADDR_SIGNAL, 64'hffff0000_12345678));
    send_qword(ad_qword(gpp_pkg::ADDR_LABEL, '1));
    send_qword(ad_qword(gpp_pkg::ADDR_FINISH, '0));
    send_qword(ad_qword(ADDR_UNUSED, {$urandom, $urandom}));
    send_qword(ad_qword(gpp_pkg::ADDR_SIGNAL, {$urandom, $urandom}));
    send_qword(random_qword());
    send_qword(clear_item());
    send_qword(ad_qword(gpp_pkg::ADDR_SIGNAL, 64'h0000ffff_0000abcd));
  endtask

  // Tags with a zero loop count, at both extremes of the other bits
  task automatic test_zero_loop_tags();
    gpp_pkg::gpp_in_t it;
    it.kind    = gpp_pkg::KIND_DATA;
    it.data_lo = {4'hf, 2'b11, 42'h3ff_ffff_ffff, 1'b1, 15'h0};
    it.data_hi = '1;
    send_qword(it);
    it.data_lo = '0;
    it.data_hi = '0;
    send_qword(it);
  endtask

  // Register list with an odd tail, then both image modes
  task automatic test_reglist_and_image();
    send_qword(tag_qword(15'd1, 1'b0, gpp_pkg::MODE_REGLIST, 4'd3, 64'h0123_4567_89ab_cdef));
    send_qword(random_qword());
    send_qword(random_qword());
    send_qword(tag_qword(15'd2, 1'b1, MODE_IMAGE, 4'd0, '1));
    send_qword(ad_qword(8'hff, '1));
    send_qword(ad_qword(8'h00, '0));
    send_qword(tag_qword(15'd1, 1'b0, MODE_IMAGE_ALT, 4'd5, '0));
    send_qword(random_qword());
  endtask

  // Unmask the interrupt and raise it with a first SIGNAL
  task automatic test_signal_irq();
    write_irq_mask(1'b0);
    send_qword(clear_item());
    send_qword(tag_qword(15'd1, 1'b1, gpp_pkg::MODE_PACKED, 4'd1,
                         {60'h0, gpp_pkg::DESC_AD}));
    send_qword(ad_qword(gpp_pkg::ADDR_SIGNAL, {$urandom, $urandom}));
  endtask

  // Hold the output for a long stretch while the input keeps offering data
  task automatic test_output_hold();
    in_idle_pct = 0;
    hold_requests++;
    send_qword(tag_qword(15'd40, 1'b0, MODE_IMAGE, 4'd0, {$urandom, $urandom}));
    while (p_loops != '0) send_qword(random_qword());
    in_idle_pct = IDLE_PCT;
    wait_parser_idle();
  endtask

  // One well-formed packet with random content, broken up now and then by host clears
  task automatic send_random_packet();
    gpp_pkg::gpp_in_t it;
    logic [63:0]      regs;
    logic [63:0]      lo;
    logic [1:0]       mode;
    int               sel;
    sel  = $urandom_range(9);
    mode = (sel < 5) ? gpp_pkg::MODE_PACKED : (sel < 8) ? gpp_pkg::MODE_REGLIST :
           (sel == 8) ? MODE_IMAGE : MODE_IMAGE_ALT;
    for (int i = 0; i < 16; i++)
      regs[i*4 +: 4] = ($urandom_range(1) == 0) ? gpp_pkg::DESC_AD : 4'($urandom);
    lo         = {$urandom, $urandom};
    lo[14:0]   = ($urandom_range(7) == 0) ? 15'd0 : 15'($urandom_range(1, 6));
    lo[59:58]  = mode;
    it.kind    = gpp_pkg::KIND_DATA;
    it.data_lo = lo;
    it.data_hi = regs;
    send_qword(it);
    while (p_loops != '0) begin
      if ((p_dbl && $urandom_range(2) != 0) || $urandom_range(24) == 0) begin
        send_qword(clear_item());
      end else begin
        it = random_qword();
        // steer A+D qwords onto the addresses that act
        if (p_mode == gpp_pkg::MODE_PACKED && cur_reg() == gpp_pkg::DESC_AD) begin
          case ($urandom_range(3))
            0:       it.data_hi[7:0] = gpp_pkg::ADDR_SIGNAL;
            1:       it.data_hi[7:0] = gpp_pkg::ADDR_FINISH;
            2:       it.data_hi[7:0] = gpp_pkg::ADDR_LABEL;
            default: ;
          endcase
        end
        send_qword(it);
      end
    end
  endtask

  task automatic test_random_traffic(int n_items, logic mask);
    int target;
    write_irq_mask(mask);
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(19) == 0) send_qword(clear_item());
      else send_random_packet();
    end
    wait_parser_idle();
  endtask

  // Long image packet at full rate with no idling on either side
  task automatic test_back_to_back();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_qword(tag_qword(15'd150, 1'b1, MODE_IMAGE_ALT, 4'd0, {$urandom, $urandom}));
    while (p_loops != '0) send_qword(random_qword());
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  // Give up if the run hangs
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("giftag_path_parser test failed");
    $finish;
  end

  initial begin : run_tests
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_packed_ad_writes();
    test_zero_loop_tags();
    test_reglist_and_image();
    test_signal_irq();
    test_output_hold();
    test_random_traffic(500, 1'b0);
    test_random_traffic(500, 1'b1);
    test_back_to_back();

    // Drain the remaining results, then let the bench settle
    in_valid_i <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && qword_result_q.size() != 0; n++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (qword_result_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", qword_result_q.size()));
    if (mismatches == 0) begin
      $display("giftag_path_parser test passed");
    end else begin
      $display("giftag_path_parser test failed");
    end
    $finish;
  end

endmodule
